@@ hw/rtl/ble_pkg.sv @@
package ble_pkg;

  localparam int unsigned MAX_LINKS    = 256;
  localparam int unsigned LINK_AW      = $clog2(MAX_LINKS);
  localparam int unsigned LINK_CW      = $clog2(MAX_LINKS + 1);
  localparam int unsigned MAX_EXPONENT = 15;
  localparam int unsigned EXP_W        = 4;
  localparam int unsigned APB_AW       = 3;

  localparam logic [46:0] LIM47       = '1;
  localparam logic signed [47:0] ONE_Q16 = 48'sd65536;

  // Register indexes of the configuration port.
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_COUNT = 1'b1;

  // Objective modes.
  localparam logic [1:0] MODE_SO     = 2'd0;
  localparam logic [1:0] MODE_UE     = 2'd1;
  localparam logic [1:0] MODE_DERIV  = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  typedef struct packed {
    logic signed [31:0] flow;
    logic signed [31:0] dir;
    logic [30:0]        t0;
    logic [30:0]        fac;
    logic [30:0]        cap;
    logic [EXP_W-1:0]   expo;
  } link_rec_t;

  typedef struct packed {
    logic               sat;
    logic signed [47:0] val;
  } clamp_t;

  function automatic clamp_t clamp48(input logic signed [49:0] v);
    clamp_t r;
    r.sat = 1'b0;
    r.val = v[47:0];
    if (v > 50'sh0_7FFF_FFFF_FFFF) begin
      r.sat = 1'b1;
      r.val = {1'b0, LIM47};
    end else if (v < -50'sh0_8000_0000_0000) begin
      r.sat = 1'b1;
      r.val = {1'b1, 47'b0};
    end
    return r;
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] v);
    return v[47] ? 48'(-v) : 48'(v);
  endfunction

endpackage

@@ hw/rtl/bpr_link_objective_evaluator_unit.sv @@
// Line search objective over a table of BPR road links.
// Input channel (in_valid_i / in_ready_o): a write beat stores one link record
// at link_index_i; an evaluate beat brings step_size_i and returns one result
// beat on the output channel (out_valid_o / out_ready_i)
// with the saturated Q31.16 total and the saturated_o flag.
// The block works on one beat at a time and takes no input while evaluating.
// All arithmetic runs through one 48 x 16 multiplier (a Q16 product is issued,
// summed from three partial products and then registered as the result, and
// each step of the power loop is one product) and one restoring divider (an
// issue step, 64 quotient bits at one per cycle and a result step).
// A link with exponent p runs p steps of the power loop, the integral mode adds
// a division by p + 1, and the ratio needs a division when the flow and the
// capacity are both nonzero. In mode 3 or with a link count of zero the
// sequencer goes straight to its final state; in_ready_o rises again in the
// same cycle as the result is loaded into the output register.
// The result is held in an output register: while the receiver stalls, the
// result waits there and the block still takes write beats and may start the
// next evaluation, which then waits in its last state until the register frees.
// Reset clears the sequencer and the output valid flag and sets the registers
// (mode 1, link count 0); the link table holds no defined contents until written.
module bpr_link_objective_evaluator_unit
  import ble_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      req_type_i,
  input  logic [7:0]                link_index_i,
  input  logic signed [31:0]        base_flow_i,
  input  logic signed [31:0]        search_direction_i,
  input  logic [30:0]               free_time_i,
  input  logic [30:0]               bpr_factor_i,
  input  logic [30:0]               link_capacity_i,
  input  logic [3:0]                bpr_exponent_i,
  input  logic signed [31:0]        step_size_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [47:0]        objective_value_o,
  output logic                      saturated_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_AW-1:0]         paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_X, S_X2, S_R, S_POW, S_POW2, S_M, S_U, S_V1, S_V2, S_V3,
    S_G, S_T1, S_T2, S_MUL, S_MULF, S_DIV, S_DIVF, S_DONE
  } state_e;

  state_e st_q, ret_q;

  logic [1:0]          mode_q;
  logic [LINK_CW-1:0]  count_q, n_q, idx_q;
  logic signed [31:0]  step_q;
  logic signed [47:0]  x_q, r_q, pw_q, u_q, g_q, res_q, sum_q;
  logic [EXP_W-1:0]    k_q;
  logic                sat_q;

  logic [47:0]         ma_q, mb_q;
  logic                mneg_q;
  logic [95:0]         macc_q;
  logic [1:0]          mcnt_q;

  logic [63:0]         dq_q;
  logic [30:0]         drem_q, dsor_q;
  logic                dneg_q;
  logic [5:0]          dcnt_q;

  logic                ovalid_q, osat_q;
  logic signed [47:0]  oval_q;

  link_rec_t           rec, wrec;
  logic                ram_we;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      REG_MODE:  prdata = {30'b0, mode_q};
      REG_COUNT: prdata = {{(32-LINK_CW){1'b0}}, count_q};
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- table
  assign ram_we     = (st_q == S_IDLE) && in_valid_i && (req_type_i == REQ_WRITE);
  assign wrec.flow  = base_flow_i;
  assign wrec.dir   = search_direction_i;
  assign wrec.t0    = free_time_i;
  assign wrec.fac   = bpr_factor_i;
  assign wrec.cap   = link_capacity_i;
  assign wrec.expo  = (bpr_exponent_i > EXP_W'(MAX_EXPONENT)) ?
                      EXP_W'(MAX_EXPONENT) : bpr_exponent_i;

  ble_ram #(
    .WIDTH ($bits(link_rec_t)),
    .DEPTH (MAX_LINKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (link_index_i[LINK_AW-1:0]),
    .wdata_i (wrec),
    .raddr_i (idx_q[LINK_AW-1:0]),
    .rdata_o (rec)
  );

  // ---------------------------------------------------------------- datapath
  logic signed [47:0] t0_s, fac_s, dir_s;
  assign t0_s  = {17'b0, rec.t0};
  assign fac_s = {17'b0, rec.fac};
  assign dir_s = 48'(rec.dir);

  // Multiplier operand selection by the sequencer.
  logic               mul_go;
  logic signed [47:0] mul_a, mul_b;
  state_e             mul_ret;
  always_comb begin
    mul_go  = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    mul_ret = S_IDLE;
    unique case (st_q)
      S_X: begin
        mul_go = 1'b1; mul_a = 48'(step_q); mul_b = dir_s; mul_ret = S_X2;
      end
      S_POW: begin
        mul_go = (k_q != rec.expo); mul_a = pw_q; mul_b = r_q; mul_ret = S_POW2;
      end
      S_M: begin
        mul_go = 1'b1;
        if (mode_q == MODE_UE) begin
          mul_a = t0_s; mul_b = x_q; mul_ret = S_U;
        end else begin
          mul_a = fac_s; mul_b = pw_q; mul_ret = S_G;
        end
      end
      S_U: begin
        mul_go = 1'b1; mul_a = res_q; mul_b = fac_s; mul_ret = S_V1;
      end
      S_V1: begin
        mul_go = 1'b1; mul_a = res_q; mul_b = pw_q; mul_ret = S_V2;
      end
      S_G: begin
        mul_go = 1'b1; mul_a = (mode_q == MODE_SO) ? x_q : dir_s; mul_b = t0_s;
        mul_ret = S_T1;
      end
      S_T1: begin
        mul_go = 1'b1; mul_a = res_q; mul_b = g_q; mul_ret = S_T2;
      end
      default: ;
    endcase
  end

  logic [63:0]        pp;
  logic               mbig;
  logic [46:0]        mq;
  logic signed [47:0] mul_res;
  assign pp      = ma_q * mb_q[{mcnt_q, 4'b0} +: 16];
  assign mbig    = |macc_q[95:63];
  assign mq      = mbig ? LIM47 : macc_q[62:16];
  assign mul_res = mneg_q ? -$signed({1'b0, mq}) : $signed({1'b0, mq});

  logic [31:0]        rsh;
  logic               dge;
  logic               dbig;
  logic [46:0]        dqm;
  logic signed [47:0] div_res;
  assign rsh     = {drem_q, dq_q[63]};
  assign dge     = rsh >= {1'b0, dsor_q};
  assign dbig    = |dq_q[63:47];
  assign dqm     = dbig ? LIM47 : dq_q[46:0];
  assign div_res = dneg_q ? -$signed({1'b0, dqm}) : $signed({1'b0, dqm});

  clamp_t cx, cg, cu, csum;
  logic signed [47:0] term;
  assign cx   = clamp48(50'(rec.flow) + 50'(res_q));
  assign cg   = clamp48(50'(ONE_Q16) + 50'(res_q));
  assign cu   = clamp48(50'(u_q) + 50'(res_q));
  assign term = (st_q == S_V3) ? cu.val : res_q;
  assign csum = clamp48(50'(sum_q) + 50'(term));

  logic [LINK_CW-1:0] idx_nx;
  assign idx_nx = idx_q + 1'b1;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= S_IDLE;
      ret_q    <= S_IDLE;
      mode_q   <= MODE_UE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        unique case (paddr[2])
          REG_MODE:  mode_q  <= pwdata[1:0];
          REG_COUNT: count_q <= pwdata[LINK_CW-1:0];
          default:   ;
        endcase
      end

      // In the final state the output register is reloaded below instead.
      if (ovalid_q && out_ready_i && (st_q != S_DONE)) begin
        ovalid_q <= 1'b0;
      end

      if (mul_go) begin
        ma_q   <= mag48(mul_a);
        mb_q   <= mag48(mul_b);
        mneg_q <= mul_a[47] ^ mul_b[47];
        macc_q <= '0;
        mcnt_q <= '0;
        ret_q  <= mul_ret;
        st_q   <= S_MUL;
      end

      unique case (st_q)
        S_IDLE: begin
          if (in_valid_i && req_type_i == REQ_EVAL) begin
            step_q <= step_size_i;
            sum_q  <= '0;
            sat_q  <= 1'b0;
            idx_q  <= '0;
            n_q    <= (count_q > LINK_CW'(MAX_LINKS)) ? LINK_CW'(MAX_LINKS) : count_q;
            if (mode_q > MODE_DERIV || count_q == '0) begin
              st_q <= S_DONE;
            end else begin
              st_q <= S_RD;
            end
          end
        end
        S_RD: st_q <= S_X;
        S_X2: begin
          x_q   <= cx.val;
          sat_q <= sat_q | cx.sat;
          pw_q  <= ONE_Q16;
          k_q   <= '0;
          if (cx.val == '0) begin
            r_q  <= '0;
            st_q <= S_POW;
          end else if (rec.cap == '0) begin
            // Zero capacity: the ratio saturates with the sign of the flow.
            r_q   <= cx.val[47] ? -$signed({1'b0, LIM47}) : $signed({1'b0, LIM47});
            sat_q <= 1'b1;
            st_q  <= S_POW;
          end else begin
            dq_q   <= {mag48(cx.val), 16'b0};
            drem_q <= '0;
            dsor_q <= rec.cap;
            dneg_q <= cx.val[47];
            dcnt_q <= '0;
            ret_q  <= S_R;
            st_q   <= S_DIV;
          end
        end
        S_R:    st_q <= S_POW;
        S_POW: begin
          if (k_q == rec.expo) st_q <= S_M;
        end
        S_POW2: begin
          pw_q <= res_q;
          k_q  <= k_q + 1'b1;
          st_q <= S_POW;
        end
        S_U:    u_q <= res_q;
        S_V2: begin
          dq_q   <= {16'b0, mag48(res_q)};
          drem_q <= '0;
          dsor_q <= 31'(rec.expo) + 31'd1;
          dneg_q <= res_q[47];
          dcnt_q <= '0;
          ret_q  <= S_V3;
          st_q   <= S_DIV;
        end
        S_G: begin
          g_q   <= cg.val;
          sat_q <= sat_q | cg.sat;
        end
        S_V3, S_T2: begin
          sum_q <= csum.val;
          sat_q <= sat_q | csum.sat | ((st_q == S_V3) & cu.sat);
          idx_q <= idx_nx;
          st_q  <= (idx_nx == n_q) ? S_DONE : S_RD;
        end
        S_MUL: begin
          macc_q <= macc_q + ({32'b0, pp} << {mcnt_q, 4'b0});
          mcnt_q <= mcnt_q + 1'b1;
          if (mcnt_q == 2'd2) st_q <= S_MULF;
        end
        S_MULF: begin
          res_q <= mul_res;
          sat_q <= sat_q | mbig;
          st_q  <= ret_q;
        end
        S_DIV: begin
          drem_q <= dge ? 31'(rsh - {1'b0, dsor_q}) : rsh[30:0];
          dq_q   <= {dq_q[62:0], dge};
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == '1) st_q <= S_DIVF;
        end
        S_DIVF: begin
          res_q <= div_res;
          r_q   <= div_res;
          sat_q <= sat_q | dbig;
          st_q  <= ret_q;
        end
        S_DONE: begin
          if (!ovalid_q || out_ready_i) begin
            ovalid_q <= 1'b1;
            oval_q   <= sum_q;
            osat_q   <= sat_q;
            st_q     <= S_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ready_o        = (st_q == S_IDLE);
  assign out_valid_o       = ovalid_q;
  assign objective_value_o = oval_q;
  assign saturated_o       = osat_q;

`ifndef SYNTHESIS
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_X) |-> (idx_q < n_q))
    else $error("link index beyond the link count");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_DIV) |-> (dsor_q != '0))
    else $error("division by zero");
  a_pow_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_POW) |-> (k_q <= rec.expo))
    else $error("power loop ran past the exponent");
`endif

endmodule

@@ hw/rtl/ble_ram.sv @@
module ble_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ tb/sv/bpr_objective_checker.sv @@
`timescale 1ns / 100ps

module bpr_objective_checker
  import ble_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               req_type_i,
  input  logic [7:0]         link_index_i,
  input  logic signed [31:0] base_flow_i,
  input  logic signed [31:0] search_direction_i,
  input  logic [30:0]        free_time_i,
  input  logic [30:0]        bpr_factor_i,
  input  logic [30:0]        link_capacity_i,
  input  logic [3:0]         bpr_exponent_i,
  input  logic signed [31:0] step_size_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [47:0] objective_value_i,
  input  logic               saturated_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [APB_AW-1:0]  paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic               pready_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 totals_seen_o,
  output int                 clamped_seen_o
);

  localparam longint TOP48 = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint BOT48 = -64'sh0000_8000_0000_0000;
  localparam longint Q16_ONE = 64'sd65536;

  typedef struct {
    longint total;
    bit     clamped;
  } objective_t;

  objective_t expected_totals[$];

  logic [1:0] mode_q;
  logic [8:0] count_q;
  longint     flow_tab[MAX_LINKS];
  longint     dir_tab[MAX_LINKS];
  longint     t0_tab[MAX_LINKS];
  longint     fac_tab[MAX_LINKS];
  longint     cap_tab[MAX_LINKS];
  int         exp_tab[MAX_LINKS];
  bit         clip_flag;

  function automatic longint unsigned abs64(longint a);
    return a < 0 ? longint'(-a) : a;
  endfunction

  function automatic longint clip48(longint x);
    if (x > TOP48) begin
      clip_flag = 1'b1;
      return TOP48;
    end
    if (x < BOT48) begin
      clip_flag = 1'b1;
      return BOT48;
    end
    return x;
  endfunction

  // Q16 product, truncated toward zero, magnitude held to 2^47-1.
  function automatic longint q16_mul(longint a, longint b);
    bit                neg;
    longint unsigned   ua, ub, q;
    neg = (a < 0) != (b < 0);
    ua = abs64(a);
    ub = abs64(b);
    if (ua == 0 || ub == 0) return 0;
    if (ua > 64'h7FFF_FFFF_FFFF_FFFF / ub) begin
      clip_flag = 1'b1;
      q = TOP48;
    end else begin
      q = (ua * ub) >> 16;
      if (q > TOP48) begin
        clip_flag = 1'b1;
        q = TOP48;
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint flow_ratio(longint x, longint cap);
    longint unsigned ux, q;
    ux = abs64(x);
    if (ux == 0) return 0;
    if (cap <= 0) begin
      clip_flag = 1'b1;
      q = TOP48;
    end else begin
      q = (ux << 16) / longint'(cap);
      if (q > TOP48) begin
        clip_flag = 1'b1;
        q = TOP48;
      end
    end
    return x < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint link_cost(int i, longint step);
    longint          x, r, pw, g, u, v;
    longint unsigned uv;
    pw = Q16_ONE;
    x = clip48(flow_tab[i] + q16_mul(step, dir_tab[i]));
    r = flow_ratio(x, cap_tab[i]);
    for (int k = 0; k < exp_tab[i]; k++) pw = q16_mul(pw, r);
    if (mode_q == MODE_UE) begin
      u = q16_mul(t0_tab[i], x);
      v = q16_mul(q16_mul(u, fac_tab[i]), pw);
      uv = abs64(v) / longint'(exp_tab[i] + 1);
      v = v < 0 ? -longint'(uv) : longint'(uv);
      return clip48(u + v);
    end
    g = clip48(Q16_ONE + q16_mul(fac_tab[i], pw));
    if (mode_q == MODE_SO) return q16_mul(q16_mul(x, t0_tab[i]), g);
    return q16_mul(q16_mul(dir_tab[i], t0_tab[i]), g);
  endfunction

  function automatic objective_t predict_objective(longint step);
    objective_t res;
    int         n;
    res.total = 0;
    clip_flag = 1'b0;
    n = (count_q > MAX_LINKS) ? MAX_LINKS : int'(count_q);
    if (mode_q != MODE_UNUSED) begin
      for (int i = 0; i < n; i++) res.total = clip48(res.total + link_cost(i, step));
    end
    res.clamped = clip_flag;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    objective_t want;
    if (!rst_ni) begin
      mode_q = MODE_UE;
      count_q = '0;
      expected_totals.delete();
      fail_count_o = 0;
      totals_seen_o = 0;
      clamped_seen_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        if (paddr_i == {REG_MODE, 2'b00}) mode_q = pwdata_i[1:0];
        else if (paddr_i == {REG_COUNT, 2'b00}) count_q = pwdata_i[8:0];
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_totals.size() == 0) begin
          $error("result beat with nothing expected: value %0d", objective_value_i);
          fail_count_o++;
        end else begin
          want = expected_totals.pop_front();
          totals_seen_o++;
          if (want.clamped) clamped_seen_o++;
          if (longint'(objective_value_i) != want.total) begin
            $error("objective_value: expected %0d, actual %0d", want.total,
                   objective_value_i);
            fail_count_o++;
          end
          if (saturated_i != want.clamped) begin
            $error("saturated: expected %0b, actual %0b", want.clamped, saturated_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == REQ_WRITE) begin
          flow_tab[link_index_i] = longint'(base_flow_i);
          dir_tab[link_index_i]  = longint'(search_direction_i);
          t0_tab[link_index_i]   = longint'({1'b0, free_time_i});
          fac_tab[link_index_i]  = longint'({1'b0, bpr_factor_i});
          cap_tab[link_index_i]  = longint'({1'b0, link_capacity_i});
          exp_tab[link_index_i]  = int'(bpr_exponent_i);
        end else begin
          expected_totals.push_back(predict_objective(longint'(step_size_i)));
        end
      end
    end
    pending_o = expected_totals.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import ble_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic               req_type_i = REQ_WRITE;
  logic [7:0]         link_index_i = '0;
  logic signed [31:0] base_flow_i = '0;
  logic signed [31:0] search_direction_i = '0;
  logic [30:0]        free_time_i = '0;
  logic [30:0]        bpr_factor_i = '0;
  logic [30:0]        link_capacity_i = '0;
  logic [3:0]         bpr_exponent_i = '0;
  logic signed [31:0] step_size_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [47:0] objective_value_o;
  logic               saturated_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int  fail_count, pending, totals_seen, clamped_seen;
  int  cycles = 0;
  int  writes_sent = 0;
  bit  calm = 1'b0;
  bit  written[MAX_LINKS];
  bit  modes_used[4];

  bpr_link_objective_evaluator_unit dut (.*);

  bpr_objective_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .link_index_i,
    .base_flow_i, .search_direction_i, .free_time_i, .bpr_factor_i, .link_capacity_i,
    .bpr_exponent_i, .step_size_i, .out_valid_i(out_valid_o), .out_ready_i,
    .objective_value_i(objective_value_o), .saturated_i(saturated_o),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .fail_count_o(fail_count),
    .pending_o(pending), .totals_seen_o(totals_seen), .clamped_seen_o(clamped_seen)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // The receiver stalls in bursts, and never once the closing stretch begins.
  initial begin
    forever begin
      @(negedge clk_i);
      if (calm || $urandom_range(0, 2) != 0) begin
        out_ready_i = 1'b1;
        repeat ($urandom_range(0, 29)) @(negedge clk_i);
      end else begin
        out_ready_i = 1'b0;
        repeat ($urandom_range(0, 17)) @(negedge clk_i);
      end
    end
  end

  function automatic logic [31:0] pick_q16();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 4) return $urandom_range(0, 16 * 65536) - 8 * 65536;
    if (sel <= 6) return $urandom;
    if (sel == 7) return 32'h7FFF_FFFF;
    if (sel == 8) return 32'h8000_0000;
    return '0;
  endfunction

  function automatic logic [30:0] pick_u31(int small_hi);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return 31'($urandom_range(1, small_hi));
    if (sel <= 7) return 31'($urandom);
    if (sel == 8) return '1;
    return '0;
  endfunction

  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < MAX_LINKS && written[n]) n++;
    return n;
  endfunction

  task automatic beat_handshake();
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 17)) @(negedge clk_i);
    end
  endtask

  task automatic write_link(int idx, logic [31:0] flow, logic [31:0] dir, logic [30:0] t0,
                            logic [30:0] fac, logic [30:0] cap, logic [3:0] expo);
    maybe_gap();
    @(negedge clk_i);
    req_type_i = REQ_WRITE;
    link_index_i = 8'(idx);
    base_flow_i = flow;
    search_direction_i = dir;
    free_time_i = t0;
    bpr_factor_i = fac;
    link_capacity_i = cap;
    bpr_exponent_i = expo;
    step_size_i = $urandom;
    beat_handshake();
    written[idx] = 1'b1;
    writes_sent++;
  endtask

  task automatic random_write(int idx);
    write_link(idx, pick_q16(), pick_q16(), pick_u31(4 * 65536), pick_u31(2 * 65536),
               ($urandom_range(0, 7) == 0) ? 31'd0 : pick_u31(16 * 65536),
               4'($urandom_range(0, 15)));
  endtask

  task automatic evaluate(logic [31:0] step);
    maybe_gap();
    @(negedge clk_i);
    req_type_i = REQ_EVAL;
    step_size_i = step;
    link_index_i = 8'($urandom);
    base_flow_i = $urandom;
    search_direction_i = $urandom;
    beat_handshake();
  endtask

  // Registers change only once every result is home and any write has settled.
  task automatic configure(logic [1:0] mode, logic [8:0] count);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {REG_MODE, 2'b00};
    pwdata = {30'($urandom), mode};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    penable = 1'b0;
    paddr = {REG_COUNT, 2'b00};
    pwdata = {23'($urandom), count};
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    modes_used[mode] = 1'b1;
  endtask

  task automatic random_phase(int items);
    int prefix;
    for (int k = 0; k < items; k++) begin
      if (k % 12 == 0) begin
        prefix = written_prefix();
        configure(($urandom_range(0, 9) == 0) ? MODE_UNUSED : 2'($urandom_range(0, 2)),
                  9'($urandom_range(0, prefix < 10 ? prefix : 10)));
      end
      if ($urandom_range(0, 9) < 4)
        random_write(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                 : $urandom_range(0, 9));
      else
        evaluate(pick_q16());
    end
  endtask

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: ordinary links, zero capacity with and without flow, and extremes.
    write_link(0, 32'sd3 << 16, -32'sd1 << 16, 31'd2 << 16, 31'd9830, 31'd5 << 16, 4'd4);
    write_link(1, 32'sd7 << 16, 32'sd2 << 16, 31'd1 << 16, 31'd1 << 16, 31'd0, 4'd2);
    write_link(2, 32'sd0, 32'sd0, 31'd3 << 16, 31'd1 << 16, 31'd0, 4'd3);
    write_link(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1, 4'd15);
    write_link(4, 32'h8000_0000, 32'h8000_0000, '0, '0, 31'd1, 4'd0);
    write_link(5, -32'sd2 << 16, 32'sd1 << 16, 31'd1 << 16, 31'd4 << 16, 31'd1 << 16, 4'd1);
    random_write(6);
    random_write(7);
    configure(MODE_SO, 9'd8);
    evaluate(32'sd0);
    evaluate(32'sd1 << 16);
    evaluate(32'h7FFF_FFFF);
    configure(MODE_UE, 9'd3);
    evaluate(32'sd1 << 15);
    evaluate(32'h8000_0000);
    configure(MODE_DERIV, 9'd6);
    evaluate(-32'sd1 << 16);
    configure(MODE_UNUSED, 9'd8);
    evaluate(32'sd1 << 16);
    configure(MODE_SO, 9'd0);
    evaluate(32'sd5 << 16);

    random_phase(90);

    // Fill the whole table, then sum it in full and with an oversized count.
    for (int i = 0; i < MAX_LINKS; i++)
      write_link(i, $urandom_range(0, 64 * 65536), $urandom_range(0, 16 * 65536) - 8 * 65536,
                 pick_u31(4 * 65536), 31'($urandom_range(0, 65536)),
                 31'($urandom_range(1, 64 * 65536)), 4'($urandom_range(0, 15)));
    configure(MODE_SO, 9'd256);
    evaluate(32'sd1 << 14);
    configure(MODE_UE, 9'd511);
    evaluate(-32'sd1 << 14);
    configure(MODE_DERIV, 9'd257);
    evaluate(32'sd0);

    calm = 1'b1;
    random_phase(15);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    $display("Sent %0d link writes; %0d totals checked, %0d of them clamped.",
             writes_sent, totals_seen, clamped_seen);
    $display("Objective modes exercised: SO=%0b UE=%0b DERIV=%0b unused=%0b.",
             modes_used[0], modes_used[1], modes_used[2], modes_used[3]);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/ble_pkg.sv
hw/rtl/ble_ram.sv
hw/rtl/bpr_link_objective_evaluator_unit.sv
tb/sv/bpr_objective_checker.sv
tb/sv/tb_top.sv
